/* hdl/stws_pkg.sv */
// ----------------------------------------------------------------------------
// stws_pkg: shared types and constants of the weighted sum tree selector
// Tree geometry, node address width, the queued word format and back states.
// ----------------------------------------------------------------------------
package stws_pkg;

	localparam int LEAVES      = 1024;
	localparam int WEIGHT_BITS = 32;

	// fixed port widths
	localparam int IDX_W = 10;
	localparam int W_W   = 32;
	localparam int FRAC_W = 32;
	localparam int SUM_W = 42;
	localparam int CNT_W = 11;

	// tree geometry: leaves padded to a power of two
	localparam int LVL     = (LEAVES > 1) ? $clog2(LEAVES) : 1;
	localparam int SPAN    = 1 << LVL;
	localparam int NODES   = 2 * SPAN - 1;
	localparam int NODE_AW = LVL + 1;

	localparam logic [NODE_AW-1:0] LEAF_BASE = NODE_AW'(SPAN - 1);
	localparam logic [NODE_AW-1:0] LAST_NODE = NODE_AW'(NODES - 1);
	localparam logic [W_W-1:0] WMASK =
		(WEIGHT_BITS >= W_W) ? {W_W{1'b1}} : W_W'((64'd1 << WEIGHT_BITS) - 64'd1);

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	// classified word handed from front to back
	typedef struct packed {
		op_t                op;
		logic               in_range;
		logic [NODE_AW-1:0] leaf_node;
		logic [W_W-1:0]     weight;
		logic [FRAC_W-1:0]  frac;
	} item_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_ULEAF,
		ST_UWALK,
		ST_SMUL1,
		ST_SMUL2,
		ST_SADD,
		ST_SDESC,
		ST_FIN
	} bstate_t;

endpackage

/* hdl/sum_tree_weighted_selector.sv */
// ----------------------------------------------------------------------------
// sum_tree_weighted_selector: weighted random index selector over a sum tree
// Top level joining the input queue and the tree engine.
// ----------------------------------------------------------------------------
// After reset the block zeroes its 2047-node tree memory, one node a cycle,
// and stalls input words until that clear is done. Each word then gives one
// result word. Words are handled one at a time by the tree engine, which
// makes one memory access per tree level over the single-port-read node RAM:
// an in-range update reads the leaf, writes it and the 10 parents, then the
// result; a sample dequeues, takes two multiply steps on the 32-bit fraction,
// an add, a 10-level descent and the result (empty tree: the result only).
// A two-entry input queue accepts, while not full, as the engine or result waits.
module sum_tree_weighted_selector (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [stws_pkg::IDX_W-1:0]  leaf_index,
	input  logic [stws_pkg::W_W-1:0]    new_weight,
	input  logic [stws_pkg::FRAC_W-1:0] random_fraction,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [stws_pkg::IDX_W-1:0]  selected_index,
	output logic                        none_active,
	output logic [stws_pkg::SUM_W-1:0]  total_weight,
	output logic [stws_pkg::CNT_W-1:0]  active_count
);
	import stws_pkg::*;

	logic  q_valid, q_pop, clearing;
	item_t q_item;

	stws_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.leaf_index     (leaf_index),
		.new_weight     (new_weight),
		.random_fraction(random_fraction),
		.clearing       (clearing),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop)
	);

	stws_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.clearing      (clearing),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.selected_index(selected_index),
		.none_active   (none_active),
		.total_weight  (total_weight),
		.active_count  (active_count)
	);

endmodule

/* hdl/stws_ram.sv */
// ----------------------------------------------------------------------------
// stws_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/stws_front.sv */
// ----------------------------------------------------------------------------
// stws_front: input side of the selector
// Accepts words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module stws_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [stws_pkg::IDX_W-1:0] leaf_index,
	input  logic [stws_pkg::W_W-1:0]   new_weight,
	input  logic [stws_pkg::FRAC_W-1:0] random_fraction,
	input  logic                       clearing,
	output logic                       q_valid,
	output stws_pkg::item_t            q_item,
	input  logic                       q_pop
);
	import stws_pkg::*;

	item_t      ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      cls;

	// classify the incoming word
	always_comb begin
		cls.op        = opcode ? OP_SAMPLE : OP_UPDATE;
		cls.in_range  = (32'(leaf_index) < 32'(LEAVES));
		cls.leaf_node = LEAF_BASE + NODE_AW'(leaf_index);
		cls.weight    = new_weight & WMASK;
		cls.frac      = random_fraction;
	end

	assign in_stall = clearing || (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

/* hdl/stws_back.sv */
// ----------------------------------------------------------------------------
// stws_back: tree engine of the selector
// Clears the tree, walks it for updates and samples, and holds the result word.
// ----------------------------------------------------------------------------
module stws_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  stws_pkg::item_t             q_item,
	output logic                        q_pop,
	output logic                        clearing,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [stws_pkg::IDX_W-1:0]  selected_index,
	output logic                        none_active,
	output logic [stws_pkg::SUM_W-1:0]  total_weight,
	output logic [stws_pkg::CNT_W-1:0]  active_count
);
	import stws_pkg::*;

	bstate_t state_q, state_d;

	logic               we;
	logic [NODE_AW-1:0] waddr, raddr;
	logic [SUM_W-1:0]   wdata, rdata;

	logic [NODE_AW-1:0] clr_q, node_q;
	logic [SUM_W-1:0]   cur_q, root_q, target_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [63:0]        plo_q;
	logic [SUM_W-1:0]   phi_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   sel_q;
	logic               none_q;
	logic               out_valid_q;

	logic [NODE_AW-1:0] sib, parent, left, child, psib;
	logic [SUM_W-1:0]   up_sum;
	logic               go_left, at_leaf, out_free;

	stws_ram #(.WIDTH(SUM_W), .DEPTH(NODES)) u_tree (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// node arithmetic
	always_comb begin
		sib     = node_q[0] ? node_q + NODE_AW'(1) : node_q - NODE_AW'(1);
		parent  = (node_q - NODE_AW'(1)) >> 1;
		psib    = parent[0] ? parent + NODE_AW'(1) : parent - NODE_AW'(1);
		up_sum  = cur_q + rdata;
		left    = (node_q << 1) | NODE_AW'(1);
		go_left = target_q < rdata;
		child   = go_left ? left : left + NODE_AW'(1);
		at_leaf = child >= LEAF_BASE;
		out_free = !out_valid_q || !out_stall;
	end

	assign clearing = (state_q == ST_CLR);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = node_q;
		wdata   = '0;
		raddr   = '0;
		q_pop   = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				if (clr_q == LAST_NODE) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				raddr = q_item.leaf_node;
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.op == OP_UPDATE) begin
						state_d = q_item.in_range ? ST_ULEAF : ST_FIN;
					end else begin
						state_d = (cnt_q == '0) ? ST_FIN : ST_SMUL1;
					end
				end
			end
			ST_ULEAF: begin
				we      = 1'b1;
				wdata   = cur_q;
				raddr   = sib;
				state_d = ST_UWALK;
			end
			ST_UWALK: begin
				we    = 1'b1;
				waddr = parent;
				wdata = up_sum;
				raddr = psib;
				if (parent == '0) state_d = ST_FIN;
			end
			ST_SMUL1: state_d = ST_SMUL2;
			ST_SMUL2: state_d = ST_SADD;
			ST_SADD: begin
				raddr   = NODE_AW'(1);
				state_d = ST_SDESC;
			end
			ST_SDESC: begin
				raddr = (child << 1) | NODE_AW'(1);
				if (at_leaf) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLR;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			root_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLR) clr_q <= clr_q + NODE_AW'(1);
			if (state_q == ST_ULEAF) begin
				cnt_q <= cnt_q - CNT_W'(rdata != '0) + CNT_W'(cur_q != '0);
			end
			if (state_q == ST_UWALK && parent == '0) root_q <= up_sum;
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				node_q <= q_item.leaf_node;
				cur_q  <= SUM_W'(q_item.weight);
				frac_q <= q_item.frac;
				sel_q  <= '0;
				none_q <= (q_item.op == OP_SAMPLE) && (cnt_q == '0);
			end
			ST_UWALK: begin
				cur_q  <= up_sum;
				node_q <= parent;
			end
			ST_SMUL1: plo_q <= frac_q * root_q[31:0];
			ST_SMUL2: phi_q <= frac_q * root_q[SUM_W-1:32];
			ST_SADD: begin
				target_q <= phi_q + SUM_W'(plo_q[63:32]);
				node_q   <= '0;
			end
			ST_SDESC: begin
				if (!go_left) target_q <= target_q - rdata;
				node_q <= child;
				if (at_leaf) sel_q <= IDX_W'(child - LEAF_BASE);
			end
			default: ;
		endcase
	end

	// result word
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			selected_index <= sel_q;
			none_active    <= none_q;
			total_weight   <= root_q;
			active_count   <= cnt_q;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_no_pop_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_pop) else $error("queue popped during clear");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LEAVES)) else $error("active count beyond leaves");
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && none_q) |-> (sel_q == '0))
		else $error("none flagged with an index");
	a_root_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UWALK && parent == '0) |=> (state_q == ST_FIN))
		else $error("walk did not finish at root");

endmodule
